FILE: src/segment_frame_decoder_cmd_queue_assert.svh
// Assertion macros for the segment frame decoder.
`ifndef SEGMENT_FRAME_DECODER_CMD_QUEUE_ASSERT_SVH
`define SEGMENT_FRAME_DECODER_CMD_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define SFDCQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SFDCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SFDCQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define SFDCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/sfdcq_pkg.sv
package sfdcq_pkg;

    localparam int QUEUE_DEPTH = 10;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NUM_DIGITS  = 5;

    typedef enum logic [1:0] {
        CMD_MINUS = 2'd0,
        CMD_PLUS  = 2'd1,
        CMD_LIGHT = 2'd2,
        CMD_TIMER = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        POS_TYPE  = 2'd0,
        POS_HIGH  = 2'd1,
        POS_LOW   = 2'd2,
        POS_CHECK = 2'd3
    } t_frame_pos;

    localparam logic [6:0] BLANK_PAT = 7'b0000000;
    localparam logic [6:0] DIGIT_PAT [NUM_DIGITS] = '{
        7'b1110111,
        7'b1000001,
        7'b0111011,
        7'b1101011,
        7'b1001101
    };

    localparam logic [1:0] LAST_BEAT = 2'd2;

    function automatic logic [7:0] payload_byte(input t_cmd code, input logic [1:0] beat);
        logic [7:0] mid;
        logic [7:0] chk;
        case (code)
            CMD_MINUS: begin
                mid = 8'h01;
                chk = 8'hC7;
            end
            CMD_PLUS: begin
                mid = 8'h02;
                chk = 8'h25;
            end
            CMD_LIGHT: begin
                mid = 8'h04;
                chk = 8'hF8;
            end
            default: begin
                mid = 8'h03;
                chk = 8'h7B;
            end
        endcase
        case (beat)
            2'd0:    payload_byte = 8'hF0;
            2'd1:    payload_byte = mid;
            default: payload_byte = chk;
        endcase
    endfunction

endpackage

FILE: src/sfdcq_in_if.sv
interface sfdcq_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         rx_byte;
    sfdcq_pkg::t_cmd    command_code;

    modport source (output valid, output kind, output rx_byte, output command_code,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input command_code,
                    output ready);
endinterface

FILE: src/sfdcq_out_if.sv
interface sfdcq_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] fan_speed;
    logic       light_on;
    logic       dot_lit;
    logic       last;

    modport source (output valid, output tx_valid, output tx_byte, output fan_speed,
                    output light_on, output dot_lit, output last, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input fan_speed,
                    input light_on, input dot_lit, input last, output ready);
endinterface

FILE: src/segment_frame_decoder_cmd_queue.sv
// Segment frame decoder with command queue.
// i_in carries one item per handshake: a link byte (kind 0) or a command code
// to queue (kind 1). Link bytes form 4-byte frames: type, high nibble, low
// nibble, check. On the check byte the display byte is decoded (only if it
// changed) and one queued command is popped.
// o_out carries the results of a finished frame: three payload bytes of the
// popped command, or one item with tx_valid 0 if the queue was empty. The last
// item of a frame has last set; speed, light and dot are the state after it.
// Results appear on o_out in the cycle after the check byte is taken.
// Throughput: one input item per cycle. A frame's results are held in the
// output register and leave one per cycle as o_out.ready allows (up to 3).
// Other items keep being accepted meanwhile; only an item arriving at the check
// position waits until the previous frame's last result is taken.
// A full command queue drops its oldest entry on a new push.
// Reset (i_rst_n low, synchronous) empties the queue, clears the decoded state
// and the frame position; no clearing pass, the block is ready next cycle.
`include "segment_frame_decoder_cmd_queue_assert.svh"

module segment_frame_decoder_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfdcq_in_if.sink      i_in,
    sfdcq_out_if.source   o_out
);

    localparam int CNT_W = sfdcq_pkg::CNT_W;
    localparam int IDX_W = sfdcq_pkg::IDX_W;

    sfdcq_pkg::t_frame_pos r_pos;
    sfdcq_pkg::t_frame_pos n_pos;
    logic [7:0]            r_asm;
    logic [7:0]            r_prev;
    logic                  r_dot;
    logic [2:0]            r_speed;
    logic                  r_light;
    sfdcq_pkg::t_cmd       r_fifo [sfdcq_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_count;
    logic                  r_busy;
    logic [1:0]            r_beat;
    logic                  r_has;
    sfdcq_pkg::t_cmd       r_code;

    logic                  in_acc;
    logic                  out_acc;
    logic                  out_last;
    logic                  frame_end;
    logic                  push;
    logic                  full;
    logic                  changed;
    logic [6:0]            pat;
    logic [2:0]            n_speed;
    logic                  n_light;
    logic [CNT_W:0]        tail_sum;
    logic [IDX_W-1:0]      tail_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      head_inc;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign out_last  = !r_has || (r_beat == sfdcq_pkg::LAST_BEAT);
    assign frame_end = in_acc && !i_in.kind && (r_pos == sfdcq_pkg::POS_CHECK);
    assign push      = in_acc && i_in.kind;
    assign full      = (r_count == CNT_W'(sfdcq_pkg::QUEUE_DEPTH));

    assign i_in.ready = !r_busy || (r_pos != sfdcq_pkg::POS_CHECK) || (out_acc && out_last);

    always_comb begin
        case (r_pos)
            sfdcq_pkg::POS_TYPE:  n_pos = sfdcq_pkg::POS_HIGH;
            sfdcq_pkg::POS_HIGH:  n_pos = sfdcq_pkg::POS_LOW;
            sfdcq_pkg::POS_LOW:   n_pos = sfdcq_pkg::POS_CHECK;
            default:              n_pos = sfdcq_pkg::POS_TYPE;
        endcase
    end

    // display decode
    assign changed = (r_asm != r_prev);
    assign pat     = r_asm[6:0];

    always_comb begin
        n_speed = r_speed;
        n_light = r_light;
        if (pat == sfdcq_pkg::BLANK_PAT) begin
            n_speed = 3'd0;
            n_light = 1'b0;
        end else begin
            for (int i = 0; i < sfdcq_pkg::NUM_DIGITS; i++) begin
                if (pat == sfdcq_pkg::DIGIT_PAT[i]) begin
                    n_speed = 3'(i);
                end
            end
            if (n_speed == 3'd0) begin
                n_light = 1'b1;
            end
        end
    end

    // queue indexes
    always_comb begin
        tail_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
        if (tail_sum >= (CNT_W+1)'(sfdcq_pkg::QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (CNT_W+1)'(sfdcq_pkg::QUEUE_DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
        head_inc = (r_head == IDX_W'(sfdcq_pkg::QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        wr_idx   = full ? r_head : tail_idx;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[wr_idx] <= sfdcq_pkg::t_cmd'(i_in.command_code);
        end
        if (frame_end) begin
            r_code <= r_fifo[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= sfdcq_pkg::POS_TYPE;
            r_asm   <= 8'h00;
            r_prev  <= 8'h00;
            r_dot   <= 1'b0;
            r_speed <= 3'd0;
            r_light <= 1'b0;
            r_head  <= '0;
            r_count <= '0;
            r_busy  <= 1'b0;
            r_beat  <= 2'd0;
            r_has   <= 1'b0;
        end else begin
            if (in_acc && !i_in.kind) begin
                r_pos <= n_pos;
                if (r_pos == sfdcq_pkg::POS_HIGH) begin
                    r_asm <= {i_in.rx_byte[3:0], 4'h0};
                end else if (r_pos == sfdcq_pkg::POS_LOW) begin
                    r_asm <= r_asm | i_in.rx_byte;
                end
            end

            if (frame_end && changed) begin
                r_prev  <= r_asm;
                r_dot   <= r_asm[7];
                r_speed <= n_speed;
                r_light <= n_light;
            end

            if (push) begin
                if (full) begin
                    r_head <= head_inc;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end else if (frame_end && (r_count != '0)) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
            end

            if (frame_end) begin
                r_busy <= 1'b1;
                r_beat <= 2'd0;
                r_has  <= (r_count != '0);
            end else if (out_acc) begin
                if (out_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_beat <= r_beat + 1'b1;
                end
            end
        end
    end

    assign o_out.valid     = r_busy;
    assign o_out.tx_valid  = r_has;
    assign o_out.tx_byte   = r_has ? sfdcq_pkg::payload_byte(r_code, r_beat) : 8'h00;
    assign o_out.fan_speed = r_speed;
    assign o_out.light_on  = r_light;
    assign o_out.dot_lit   = r_dot;
    assign o_out.last      = out_last;

    `SFDCQ_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1,
                       r_count <= CNT_W'(sfdcq_pkg::QUEUE_DEPTH))
    `SFDCQ_ASSERT_SAME(a_head_range, i_clk, i_rst_n, 1'b1,
                       r_head <= IDX_W'(sfdcq_pkg::QUEUE_DEPTH - 1))
    `SFDCQ_ASSERT_NEXT(a_frame_loads_burst, i_clk, i_rst_n, frame_end,
                       r_busy && (r_beat == 2'd0))
    `SFDCQ_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, out_acc && !out_last,
                       r_busy && r_has)
    `SFDCQ_ASSERT_SAME(a_beat_range, i_clk, i_rst_n, r_busy,
                       r_beat <= sfdcq_pkg::LAST_BEAT)

endmodule
